// File: design/arpg_pkg.sv
// Shared types, constants and lookup functions for the address range
// permutation generator. No dependencies.
package arpg_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 30;
    localparam int PIDX_W    = 5;
    localparam int REM_W     = 33;
    localparam int LOG2_W    = 5;
    localparam int MULT_W    = 32;
    localparam int PRIME_W   = 30;
    localparam int CHUNKS_W  = 34;
    localparam int PROD_W    = CNT_W + MULT_W;
    localparam int SHIFT_W   = PRIME_W + (1 << LOG2_W) - 1;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_W    = 8;
    localparam int SLOT_EXT_W = 13;

    // remainder unit: padded dividend, bits retired per cycle
    localparam int MOD_W      = 64;
    localparam int DIGIT_BITS = 4;
    localparam int MOD_STEPS  = MOD_W / DIGIT_BITS;
    localparam int STEP_W     = $clog2(MOD_STEPS);

    // largest usable prime index; more chunks than 2^MAX_PIDX is rejected
    localparam int MAX_PIDX = 29;

    localparam logic [MULT_W-1:0] MULT_RESET = 32'd3;

    localparam logic                 ACT_LOAD       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 1'd1;

    typedef enum logic [1:0] {
        STAT_LOADED    = 2'd0,
        STAT_CHUNK     = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_REJECTED  = 2'd3
    } arpg_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD_CHUNK,
        ST_LOAD_COMMIT,
        ST_FETCH,
        ST_MUL,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_SHIFT,
        ST_CHECK,
        ST_CEND,
        ST_UPDATE,
        ST_PUSH
    } arpg_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] last;
        logic [CNT_W-1:0]  cnt;
        logic [PIDX_W-1:0] pidx;
        logic [REM_W-1:0]  rem;
    } arpg_entry_t;

    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic load_size;
        logic load_chunk;
        logic load_commit;
        logic mem_read;
        logic fetch;
        logic mul;
        logic mod_start;
        logic shift;
        logic check;
        logic cend;
        logic update;
        logic res_exhaust;
        logic out_load;
    } arpg_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_load;
        logic slot_ok;
        logic rem_zero;
        logic fit;
        logic mod_done;
        logic mod_busy;
    } arpg_sts_t;

    // smallest prime above 2^idx; indexes past the table wrap around
    function automatic logic [PRIME_W-1:0] prime_of(input logic [PIDX_W-1:0] idx);
        logic [PRIME_W-1:0] p;
        case (idx)
            5'd0:    p = 30'd2;
            5'd1:    p = 30'd3;
            5'd2:    p = 30'd5;
            5'd3:    p = 30'd11;
            5'd4:    p = 30'd17;
            5'd5:    p = 30'd37;
            5'd6:    p = 30'd67;
            5'd7:    p = 30'd131;
            5'd8:    p = 30'd257;
            5'd9:    p = 30'd521;
            5'd10:   p = 30'd1031;
            5'd11:   p = 30'd2053;
            5'd12:   p = 30'd4099;
            5'd13:   p = 30'd8209;
            5'd14:   p = 30'd16411;
            5'd15:   p = 30'd32771;
            5'd16:   p = 30'd65537;
            5'd17:   p = 30'd131101;
            5'd18:   p = 30'd262147;
            5'd19:   p = 30'd524309;
            5'd20:   p = 30'd1048583;
            5'd21:   p = 30'd2097169;
            5'd22:   p = 30'd4194319;
            5'd23:   p = 30'd8388617;
            5'd24:   p = 30'd16777259;
            5'd25:   p = 30'd33554467;
            5'd26:   p = 30'd67108879;
            5'd27:   p = 30'd134217757;
            5'd28:   p = 30'd268435459;
            5'd29:   p = 30'd536870923;
            5'd30:   p = 30'd2;
            default: p = 30'd3;
        endcase
        return p;
    endfunction

    // ceil(log2(chunks)), valid for chunks up to 2^MAX_PIDX
    function automatic logic [PIDX_W-1:0] chunk_pidx(input logic [CHUNKS_W-1:0] chunks);
        logic [PIDX_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_PIDX; i++) begin
            if (chunks > (CHUNKS_W'(1) << i))
                n = n + PIDX_W'(1);
        end
        return n;
    endfunction

endpackage

// File: design/arpg_mod.sv
// Iterative remainder unit: dividend mod divisor, DIGIT_BITS bits per cycle.
// Depends on arpg_pkg.
module arpg_mod
    import arpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MOD_W-1:0]   dividend,
    input  logic [PRIME_W-1:0] divisor,
    output logic [PRIME_W-1:0] remainder,
    output logic               done,
    output logic               busy
);

    logic [MOD_W-1:0]   shreg_reg;
    logic [PRIME_W-1:0] rem_reg;
    logic [PRIME_W-1:0] rem_next;
    logic [PRIME_W:0]   trial;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               last_step;

    assign last_step = busy_reg && (step_reg == STEP_W'(MOD_STEPS - 1));

    // remainder stays below divisor, so one conditional subtract per bit
    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int j = 0; j < DIGIT_BITS; j++) begin
            trial = {rem_next, shreg_reg[MOD_W-1-j]};
            if (trial >= {1'b0, divisor})
                trial = trial - {1'b0, divisor};
            rem_next = trial[PRIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= last_step && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shreg_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shreg_reg <= shreg_reg << DIGIT_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign remainder = rem_reg;
    assign done      = done_reg;
    assign busy      = busy_reg;

endmodule

// File: design/arpg_dp.sv
// Datapath: configuration registers, slot table memory, draw arithmetic
// and result/output registers. Depends on arpg_pkg and arpg_mod.
module arpg_dp
    import arpg_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 action,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [ADDR_W-1:0]    range_start,
    input  logic [ADDR_W-1:0]    range_end,
    input  arpg_cmd_t            cmd,
    output arpg_sts_t            sts,
    output logic [ADDR_W-1:0]    chunk_start,
    output logic [ADDR_W-1:0]    chunk_end,
    output logic [1:0]           status,
    output logic [REM_W-1:0]     remaining
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration
    logic [LOG2_W-1:0] chunk_log2_reg;
    logic [MULT_W-1:0] mult_reg;

    // captured request
    logic              act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] rs_reg;
    logic [ADDR_W-1:0] re_reg;

    // load path
    logic [REM_W-1:0]    size_reg;
    logic                inv_reg;
    logic [CHUNKS_W-1:0] chunks_reg;

    // draw path
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  last_reg;
    logic [ADDR_W-1:0]  span_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SHIFT_W-1:0] shifted_reg;
    logic [ADDR_W-1:0]  cstart_reg;
    logic [ADDR_W-1:0]  cend_reg;
    logic [REM_W-1:0]   len_reg;

    // result and output registers
    logic [ADDR_W-1:0] res_start_reg;
    logic [ADDR_W-1:0] res_end_reg;
    arpg_status_t      res_status_reg;
    logic [REM_W-1:0]  res_rem_reg;
    logic [ADDR_W-1:0] out_start_reg;
    logic [ADDR_W-1:0] out_end_reg;
    arpg_status_t      out_status_reg;
    logic [REM_W-1:0]  out_rem_reg;

    // slot table
    arpg_entry_t mem [SLOTS];
    arpg_entry_t rd_reg;
    arpg_entry_t wr_data;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [IW-1:0] clr_idx_reg;

    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [IW-1:0]         slot_addr;
    logic                  slot_ok;
    logic [REM_W-1:0]      mask33;
    logic [ADDR_W-1:0]     mask32;
    logic [ADDR_W-1:0]     room;
    logic                  clamp;
    logic                  load_ok;
    logic [REM_W-1:0]      rem_next;

    logic [PRIME_W-1:0] mod_rem;
    logic               mod_done;
    logic               mod_busy;

    assign slot_ext  = SLOT_EXT_W'(slot_reg);
    assign slot_addr = slot_ext[IW-1:0];
    assign slot_ok   = slot_ext < SLOT_EXT_W'(SLOTS);

    assign mask33 = (REM_W'(1) << chunk_log2_reg) - REM_W'(1);
    assign mask32 = mask33[ADDR_W-1:0];
    assign room   = last_reg - cstart_reg;
    assign clamp  = mask32 > room;

    assign load_ok  = slot_ok && !inv_reg
                      && (chunks_reg <= (CHUNKS_W'(1) << MAX_PIDX));
    assign rem_next = (len_reg >= rem_reg) ? '0 : rem_reg - len_reg;

    assign sts.clear_last = clr_idx_reg == IW'(SLOTS - 1);
    assign sts.is_load    = act_reg == ACT_LOAD;
    assign sts.slot_ok    = slot_ok;
    assign sts.rem_zero   = rd_reg.rem == '0;
    assign sts.fit        = (shifted_reg[SHIFT_W-1:ADDR_W] == '0)
                            && (shifted_reg[ADDR_W-1:0] <= span_reg);
    assign sts.mod_done   = mod_done;
    assign sts.mod_busy   = mod_busy;

    arpg_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (MOD_W'(prod_reg)),
        .divisor   (prime_reg),
        .remainder (mod_rem),
        .done      (mod_done),
        .busy      (mod_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_log2_reg <= '0;
            mult_reg       <= MULT_RESET;
            clr_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CHUNK_LOG2: chunk_log2_reg <= cfg_data[LOG2_W-1:0];
                    CFG_MULTIPLIER: mult_reg       <= cfg_data[MULT_W-1:0];
                endcase
            end
            if (cmd.clear_wr)
                clr_idx_reg <= clr_idx_reg + IW'(1);
        end
    end

    // table write port: clearing pass, load, or post-draw update
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_addr;
        wr_data = '0;
        if (cmd.clear_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end
        else if (cmd.load_commit)
        begin
            wr_en        = load_ok;
            wr_data.base = rs_reg;
            wr_data.last = re_reg;
            wr_data.pidx = chunk_pidx(chunks_reg);
            wr_data.rem  = size_reg;
        end
        else if (cmd.update)
        begin
            wr_en        = 1'b1;
            wr_data.base = base_reg;
            wr_data.last = last_reg;
            wr_data.cnt  = cnt_reg;
            wr_data.pidx = pidx_reg;
            wr_data.rem  = rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_read)
            rd_reg <= mem[slot_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            slot_reg <= slot;
            rs_reg   <= range_start;
            re_reg   <= range_end;
        end

        if (cmd.load_size)
        begin
            size_reg <= {1'b0, re_reg} - {1'b0, rs_reg} + REM_W'(1);
            inv_reg  <= re_reg < rs_reg;
        end
        if (cmd.load_chunk)
            chunks_reg <= ({1'b0, size_reg} + {1'b0, mask33}) >> chunk_log2_reg;

        if (cmd.fetch)
        begin
            base_reg  <= rd_reg.base;
            last_reg  <= rd_reg.last;
            span_reg  <= rd_reg.last - rd_reg.base;
            cnt_reg   <= rd_reg.cnt;
            pidx_reg  <= rd_reg.pidx;
            prime_reg <= prime_of(rd_reg.pidx);
            rem_reg   <= rd_reg.rem;
        end

        if (cmd.mul)
            prod_reg <= PROD_W'(cnt_reg) * PROD_W'(mult_reg);
        if (cmd.shift)
            shifted_reg <= SHIFT_W'(mod_rem) << chunk_log2_reg;
        if (cmd.check)
        begin
            cstart_reg <= base_reg + shifted_reg[ADDR_W-1:0];
            cnt_reg    <= cnt_reg + CNT_W'(1);
        end
        if (cmd.cend)
        begin
            cend_reg <= clamp ? last_reg : cstart_reg + mask32;
            len_reg  <= {1'b0, (clamp ? room : mask32)} + REM_W'(1);
        end

        if (cmd.update)
        begin
            res_start_reg  <= cstart_reg;
            res_end_reg    <= cend_reg;
            res_status_reg <= STAT_CHUNK;
            res_rem_reg    <= rem_next;
        end
        else if (cmd.load_commit)
        begin
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            res_status_reg <= load_ok ? STAT_LOADED : STAT_REJECTED;
            res_rem_reg    <= load_ok ? size_reg : '0;
        end
        else if (cmd.res_exhaust)
        begin
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            res_status_reg <= STAT_EXHAUSTED;
            res_rem_reg    <= '0;
        end

        if (cmd.out_load)
        begin
            out_start_reg  <= res_start_reg;
            out_end_reg    <= res_end_reg;
            out_status_reg <= res_status_reg;
            out_rem_reg    <= res_rem_reg;
        end
    end

    assign chunk_start = out_start_reg;
    assign chunk_end   = out_end_reg;
    assign status      = out_status_reg;
    assign remaining   = out_rem_reg;

endmodule

// File: design/arpg_ctrl.sv
// Controller state machine: sequences clearing pass, loads and draws,
// owns the handshakes. Depends on arpg_pkg.
module arpg_ctrl
    import arpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  arpg_sts_t sts,
    output arpg_cmd_t cmd
);

    arpg_state_t state_reg;
    arpg_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_load)
                begin
                    cmd.load_size = 1'b1;
                    state_next    = ST_LOAD_CHUNK;
                end
                else if (!sts.slot_ok)
                begin
                    cmd.res_exhaust = 1'b1;
                    state_next      = ST_PUSH;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_LOAD_CHUNK:
            begin
                cmd.load_chunk = 1'b1;
                state_next     = ST_LOAD_COMMIT;
            end
            ST_LOAD_COMMIT:
            begin
                cmd.load_commit = 1'b1;
                state_next      = ST_PUSH;
            end
            ST_FETCH:
            begin
                if (sts.rem_zero)
                begin
                    cmd.res_exhaust = 1'b1;
                    state_next      = ST_PUSH;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_MOD_GO;
            end
            ST_MOD_GO:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (sts.mod_done)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // counter advances on every draw, skipped or not
                cmd.check  = 1'b1;
                state_next = sts.fit ? ST_CEND : ST_MUL;
            end
            ST_CEND:
            begin
                cmd.cend   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/address_range_permutation_generator.sv
// Address range permutation generator. After reset the slot table is swept
// clear, one slot per cycle, and no request is taken until the sweep is
// done; configuration writes are taken throughout. A load (action 0) works
// out the range size, then the chunk count, then commits the slot and its
// result. A next-chunk request reads its slot and, if any of the range is
// left, runs draws: each draw is one multiply of the draw count by the
// multiplier, then a remainder by the slot's prime in a radix-16 unit that
// retires 4 product bits per cycle. Draws whose chunk would start past the
// range end are skipped, so a request can take several draws. One request
// is worked on at a time; the output register lets the next request in
// while a result waits. Depends on arpg_pkg, arpg_ctrl, arpg_dp.
module address_range_permutation_generator
    import arpg_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [ADDR_W-1:0]    range_start,
    input  logic [ADDR_W-1:0]    range_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    chunk_start,
    output logic [ADDR_W-1:0]    chunk_end,
    output logic [1:0]           status,
    output logic [REM_W-1:0]     remaining
);

    arpg_cmd_t cmd;
    arpg_sts_t sts;

    arpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    arpg_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .slot        (slot),
        .range_start (range_start),
        .range_end   (range_end),
        .cmd         (cmd),
        .sts         (sts),
        .chunk_start (chunk_start),
        .chunk_end   (chunk_end),
        .status      (status),
        .remaining   (remaining)
    );

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result register overwritten while stalled");

    // remainder unit is only restarted once idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_start |-> !sts.mod_busy)
        else $error("remainder unit restarted while busy");

    // a granted chunk never ends before it starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_CHUNK) |-> (chunk_end >= chunk_start))
        else $error("chunk end below chunk start");

    // loads and exhausted requests carry no addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_CHUNK) |-> (chunk_start == '0 && chunk_end == '0))
        else $error("non-chunk result carries an address");

endmodule
